@@ hdl/per_thread_routine_profile_table_assert.svh @@
// Assertion macros for the routine profile table.
// Included by the top level; needs no package.
`ifndef PER_THREAD_ROUTINE_PROFILE_TABLE_ASSERT_SVH
`define PER_THREAD_ROUTINE_PROFILE_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PTRP_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PTRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define PTRP_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define PTRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hdl/ptrp_pkg.sv @@
// Package for the routine profile table: request and result structs.
// Used by the top level and the testbench; depends on nothing.
package ptrp_pkg;

	localparam int RoutineW = 16;
	localparam int ThreadW = 6;
	localparam int OutCountW = 48;
	localparam int DrainMax = 64;

	typedef struct packed {
		logic                mode;
		logic [RoutineW-1:0] routine_id;
		logic [ThreadW-1:0]  thread_id;
	} req_t;

	typedef struct packed {
		logic [RoutineW-1:0]   routine_out;
		logic [OutCountW-1:0]  count_out;
		logic                  empty_res;
		logic                  dropped;
		logic                  last;
	} res_t;

	localparam logic MODE_COUNT = 1'b0;
	localparam logic MODE_DRAIN = 1'b1;

endpackage

@@ hdl/ptrp_ram.sv @@
// Generic single-port RAM with registered read.
// Stand-alone; no package needed.
module ptrp_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// One read each cycle, and a write as well when we is high.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

@@ hdl/per_thread_routine_profile_table.sv @@
// Routine profile table. A request is taken when start is high and busy low;
// busy then stays high until the request is done. A count request walks the
// routine table (one slot a cycle, up to ROUTINE_SLOTS) and then, unless
// a new routine finds the routine table full, the whole pair table (all
// PAIR_ENTRIES entries, one a cycle). A drain scans the whole pair table
// once per result. Results come with res_valid high for one cycle and
// cannot be held off. All reads go through one RAM port per table, so one
// entry is visited each cycle.
// Depends on ptrp_pkg, ptrp_ram and the assertion header.
`include "per_thread_routine_profile_table_assert.svh"
module per_thread_routine_profile_table
	import ptrp_pkg::*;
#(
	parameter int PAIR_ENTRIES = 64,
	parameter int ROUTINE_SLOTS = 64,
	parameter int COUNT_BITS = 48
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic res_valid,
	output res_t res
);
	localparam int PW = $clog2(PAIR_ENTRIES);
	localparam int SW = $clog2(ROUTINE_SLOTS);
	localparam int EW = SW + ThreadW + COUNT_BITS;
	localparam logic [COUNT_BITS-1:0] CountMax = '1;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_RSCAN = 8'b0000_0010,
		ST_RCHK  = 8'b0000_0100,
		ST_PSCAN = 8'b0000_1000,
		ST_PCHK  = 8'b0001_0000,
		ST_DSCAN = 8'b0010_0000,
		ST_DCHK  = 8'b0100_0000,
		ST_KEY   = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic [SW-1:0]         slot;
		logic [ThreadW-1:0]    thread;
		logic [COUNT_BITS-1:0] count;
	} entry_t;

	state_t state_q;
	req_t req_q;
	logic [SW:0] used_q;
	logic [SW:0] rptr_q;
	logic [SW-1:0] slot_q;
	logic [PW:0] pptr_q;
	logic [PAIR_ENTRIES-1:0] valid_q;
	logic lost_q;
	logic hit_q, free_found_q, best_found_q;
	logic [PW-1:0] hit_idx_q, free_idx_q, best_idx_q;
	entry_t best_q, hit_e_q;
	logic [6:0] nres_q;
	logic first_q;

	// Shared RAM port controls.
	logic rk_we, pe_we;
	logic [SW-1:0] rk_addr;
	logic [PW-1:0] pe_addr, prd_idx_q;
	logic [RoutineW-1:0] rk_wdata, rk_rdata;
	entry_t pe_wdata, pe_rdata;
	logic [EW-1:0] pe_rbits;

	ptrp_ram #(.Width(RoutineW), .Depth(ROUTINE_SLOTS)) u_key (
		.clk(clk), .we(rk_we), .addr(rk_addr), .wdata(rk_wdata), .rdata(rk_rdata)
	);
	ptrp_ram #(.Width(EW), .Depth(PAIR_ENTRIES)) u_pair (
		.clk(clk), .we(pe_we), .addr(pe_addr), .wdata(pe_wdata), .rdata(pe_rbits)
	);
	assign pe_rdata = entry_t'(pe_rbits);

	// The pipeline: address issued in a scan state, data checked next cycle.
	logic prd_v_q, rrd_v_q;
	logic [SW-1:0] rrd_idx_q;

	logic cand_better;
	assign cand_better = !best_found_q || (pe_rdata.count > best_q.count) ||
		(pe_rdata.count == best_q.count && pe_rdata.slot < best_q.slot);

	assign busy = (state_q != ST_IDLE);

	// Address muxing for the two RAMs.
	always_comb begin
		rk_we = 1'b0;
		rk_addr = rptr_q[SW-1:0];
		rk_wdata = req_q.routine_id;
		pe_we = 1'b0;
		pe_addr = pptr_q[PW-1:0];
		pe_wdata = hit_e_q;
		unique case (state_q)
			ST_RCHK: begin
				rk_addr = used_q[SW-1:0];
				rk_we = !hit_q && (used_q < (SW+1)'(ROUTINE_SLOTS));
			end
			ST_PCHK: begin
				if (hit_q) begin
					pe_we = 1'b1;
					pe_addr = hit_idx_q;
					pe_wdata = hit_e_q;
					if (hit_e_q.count != CountMax) begin
						pe_wdata.count = hit_e_q.count + 1'b1;
					end
				end else begin
					pe_we = free_found_q;
					pe_addr = free_idx_q;
					pe_wdata.slot = slot_q;
					pe_wdata.thread = req_q.thread_id;
					pe_wdata.count = COUNT_BITS'(1);
				end
			end
			ST_DCHK: rk_addr = best_q.slot;
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= '0;
			valid_q <= '0;
			lost_q <= 1'b0;
			rptr_q <= '0;
			pptr_q <= '0;
			prd_v_q <= 1'b0;
			rrd_v_q <= 1'b0;
			hit_q <= 1'b0;
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
			res_valid <= 1'b0;
			nres_q <= '0;
			first_q <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			prd_v_q <= 1'b0;
			rrd_v_q <= 1'b0;
			prd_idx_q <= pptr_q[PW-1:0];
			rrd_idx_q <= rptr_q[SW-1:0];
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q <= req;
						rptr_q <= '0;
						pptr_q <= '0;
						hit_q <= 1'b0;
						free_found_q <= 1'b0;
						best_found_q <= 1'b0;
						nres_q <= '0;
						first_q <= 1'b1;
						state_q <= (req.mode == MODE_DRAIN) ? ST_DSCAN : ST_RSCAN;
					end
				end
				ST_RSCAN: begin
					// Compare the key read last cycle, issue the next read.
					if (rrd_v_q && rk_rdata == req_q.routine_id && !hit_q) begin
						hit_q <= 1'b1;
						slot_q <= rrd_idx_q;
					end
					if (rptr_q < used_q && !hit_q &&
						!(rrd_v_q && rk_rdata == req_q.routine_id)) begin
						rrd_v_q <= 1'b1;
						rptr_q <= rptr_q + 1'b1;
					end else if (!rrd_v_q || hit_q || rk_rdata == req_q.routine_id) begin
						state_q <= ST_RCHK;
					end
				end
				ST_RCHK: begin
					if (!hit_q) begin
						if (used_q < (SW+1)'(ROUTINE_SLOTS)) begin
							slot_q <= used_q[SW-1:0];
							used_q <= used_q + 1'b1;
							state_q <= ST_PSCAN;
						end else begin
							lost_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_PSCAN;
					end
					hit_q <= 1'b0;
				end
				ST_PSCAN: begin
					// Look for the pair and the lowest free entry.
					if (prd_v_q) begin
						if (valid_q[prd_idx_q]) begin
							if (pe_rdata.slot == slot_q &&
								pe_rdata.thread == req_q.thread_id) begin
								hit_q <= 1'b1;
								hit_idx_q <= prd_idx_q;
								hit_e_q <= pe_rdata;
							end
						end else if (!free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q <= prd_idx_q;
						end
					end
					if (pptr_q < (PW+1)'(PAIR_ENTRIES)) begin
						prd_v_q <= 1'b1;
						pptr_q <= pptr_q + 1'b1;
					end else if (!prd_v_q) begin
						state_q <= ST_PCHK;
					end
				end
				ST_PCHK: begin
					if (!hit_q) begin
						if (free_found_q) begin
							valid_q[free_idx_q] <= 1'b1;
						end else begin
							lost_q <= 1'b1;
						end
					end
					state_q <= ST_IDLE;
				end
				ST_DSCAN: begin
					// Keep the largest count, lowest slot on ties.
					if (prd_v_q && valid_q[prd_idx_q] &&
						pe_rdata.thread == req_q.thread_id && cand_better) begin
						best_found_q <= 1'b1;
						best_idx_q <= prd_idx_q;
						best_q <= pe_rdata;
					end
					if (pptr_q < (PW+1)'(PAIR_ENTRIES)) begin
						prd_v_q <= 1'b1;
						pptr_q <= pptr_q + 1'b1;
					end else if (!prd_v_q) begin
						state_q <= ST_DCHK;
					end
				end
				ST_DCHK: begin
					// Send any previous result (an empty one if the drain found nothing); finish when no entry is left.
					if (!best_found_q) begin
						if (first_q) begin
							res_valid <= 1'b1;
							res <= '{routine_out: '0, count_out: '0, empty_res: 1'b1,
								dropped: lost_q, last: 1'b1};
						end else begin
							res_valid <= 1'b1;
							res.last <= 1'b1;
							res.dropped <= lost_q;
						end
						state_q <= ST_IDLE;
					end else begin
						if (!first_q) begin
							res_valid <= 1'b1;
							res.last <= 1'b0;
							res.dropped <= lost_q;
						end
						valid_q[best_idx_q] <= 1'b0;
						state_q <= ST_KEY;
					end
				end
				ST_KEY: begin
					// Key read done; hold the result until the next scan ends, or send it as last once DrainMax is reached.
					res.routine_out <= rk_rdata;
					res.count_out <= OutCountW'(best_q.count);
					res.empty_res <= 1'b0;
					first_q <= 1'b0;
					nres_q <= nres_q + 1'b1;
					best_found_q <= 1'b0;
					pptr_q <= '0;
					if (nres_q + 7'd1 >= 7'(DrainMax)) begin
						res_valid <= 1'b1;
						res.dropped <= lost_q;
						res.last <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DSCAN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`PTRP_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy,
		"request accepted but block not busy")
	`PTRP_ASSERT_IMPL(a_res_idle, clk, arst_n, res_valid && res.last |-> !busy,
		"block still busy on last result")
	`PTRP_ASSERT_IMPL(a_empty_last, clk, arst_n, res_valid && res.empty_res |-> res.last,
		"empty result not marked last")
endmodule

@@ tb/per_thread_routine_profile_table_tb.sv @@
// Self-checking testbench for the routine profile table.
// Mirrors the table in local arrays, predicts every drain result and checks them in order.
// Depends on ptrp_pkg and the per_thread_routine_profile_table RTL.
module per_thread_routine_profile_table_tb;
	import ptrp_pkg::*;

	localparam int Entries = 64;
	localparam int Slots = 64;
	localparam int CycleLimit = 10000000;
	localparam logic [47:0] CountTop = 48'hFFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic res_valid;
	res_t res;

	per_thread_routine_profile_table dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .res_valid(res_valid), .res(res)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Mirror of the table contents.
	logic [15:0] slot_key [Slots];
	int          slots_taken = 0;
	bit          entry_valid [Entries];
	logic [5:0]  entry_slot [Entries];
	logic [5:0]  entry_thread [Entries];
	logic [47:0] entry_count [Entries];
	bit          lost = 1'b0;

	req_t pending_reqs [$];
	res_t expected_res [$];
	int   idle_pct = 0;
	bit   wait_quiet = 1'b0;
	int   errors = 0;
	int   cycles = 0;
	int   n_counts = 0;
	int   n_drains = 0;
	int   n_results = 0;

	// Add one to the (routine, thread) count, taking slots and entries as needed.
	task automatic apply_count(logic [15:0] rid, logic [5:0] tid);
		int slot;
		int free_idx;
		slot = -1;
		free_idx = -1;
		for (int i = 0; i < slots_taken; i++)
			if (slot < 0 && slot_key[i] == rid) slot = i;
		if (slot < 0) begin
			if (slots_taken >= Slots) begin
				lost = 1'b1;
				return;
			end
			slot = slots_taken;
			slot_key[slot] = rid;
			slots_taken++;
		end
		for (int i = 0; i < Entries; i++) begin
			if (entry_valid[i]) begin
				if (entry_slot[i] == slot[5:0] && entry_thread[i] == tid) begin
					if (entry_count[i] != CountTop) entry_count[i]++;
					return;
				end
			end else if (free_idx < 0) begin
				free_idx = i;
			end
		end
		if (free_idx < 0) begin
			lost = 1'b1;
			return;
		end
		entry_valid[free_idx] = 1'b1;
		entry_slot[free_idx] = slot[5:0];
		entry_thread[free_idx] = tid;
		entry_count[free_idx] = 48'd1;
	endtask

	// Largest count of the thread, earlier routine on a tie; -1 if none.
	function automatic int largest_entry(logic [5:0] tid);
		int best;
		best = -1;
		for (int i = 0; i < Entries; i++) begin
			if (!entry_valid[i] || entry_thread[i] != tid) continue;
			if (best < 0 || entry_count[i] > entry_count[best] ||
			    (entry_count[i] == entry_count[best] && entry_slot[i] < entry_slot[best]))
				best = i;
		end
		return best;
	endfunction

	// Queue the results of draining one thread.
	task automatic apply_drain(logic [5:0] tid);
		int cur;
		int nxt;
		int n;
		res_t r;
		n = 0;
		cur = largest_entry(tid);
		if (cur < 0) begin
			r = '0;
			r.empty_res = 1'b1;
			r.dropped = lost;
			r.last = 1'b1;
			expected_res.push_back(r);
			return;
		end
		while (cur >= 0 && n < DrainMax) begin
			r = '0;
			r.routine_out = slot_key[entry_slot[cur]];
			r.count_out = entry_count[cur];
			r.dropped = lost;
			entry_valid[cur] = 1'b0;
			nxt = largest_entry(tid);
			r.last = (nxt < 0 || n + 1 >= DrainMax);
			expected_res.push_back(r);
			n++;
			cur = nxt;
		end
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
		errors++;
	endtask

	// Driver: predicts each accepted request and presents the next one.
	always @(posedge clk) begin
		bit go;
		if (arst_n) begin
			if (start && !busy) begin
				if (req.mode == MODE_DRAIN) begin
					apply_drain(req.thread_id);
					n_drains++;
				end else begin
					apply_count(req.routine_id, req.thread_id);
					n_counts++;
				end
				void'(pending_reqs.pop_front());
			end
			go = pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct &&
			     !(wait_quiet && (expected_res.size() != 0 || busy));
			if (go) begin
				start <= 1'b1;
				req <= pending_reqs[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: each result strobe is checked against the oldest expectation.
	always @(posedge clk) begin
		res_t w;
		if (arst_n && res_valid) begin
			n_results++;
			if (expected_res.size() == 0) begin
				report_mismatch("unexpected result", 64'd1, 64'd0);
			end else begin
				w = expected_res.pop_front();
				if (res.routine_out !== w.routine_out)
					report_mismatch("routine_out", res.routine_out, w.routine_out);
				if (res.count_out !== w.count_out)
					report_mismatch("count_out", res.count_out, w.count_out);
				if (res.empty_res !== w.empty_res)
					report_mismatch("empty_res", res.empty_res, w.empty_res);
				if (res.dropped !== w.dropped)
					report_mismatch("dropped", res.dropped, w.dropped);
				if (res.last !== w.last)
					report_mismatch("last", res.last, w.last);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
			         cycles, expected_res.size());
			$display("per_thread_routine_profile_table_tb NOT OK");
			$finish;
		end
	end

	task automatic push_req(logic mode, logic [15:0] rid, logic [5:0] tid);
		req_t r;
		r.mode = mode;
		r.routine_id = rid;
		r.thread_id = tid;
		pending_reqs.push_back(r);
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || start || busy || expected_res.size() != 0)
			@(posedge clk);
	endtask

	logic [15:0] hot_routines [16];

	initial begin
		for (int i = 0; i < Entries; i++) entry_valid[i] = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty drain, field extremes, ties and repeat counts.
		push_req(MODE_DRAIN, 16'h0000, 6'd0);
		push_req(MODE_COUNT, 16'h0000, 6'd0);
		push_req(MODE_COUNT, 16'hFFFF, 6'd63);
		push_req(MODE_COUNT, 16'hFFFF, 6'd0);
		push_req(MODE_COUNT, 16'h0000, 6'd63);
		push_req(MODE_COUNT, 16'hA5A5, 6'd0);
		push_req(MODE_COUNT, 16'hA5A5, 6'd0);
		push_req(MODE_COUNT, 16'h5A5A, 6'd42);
		push_req(MODE_DRAIN, 16'hFFFF, 6'd0);
		push_req(MODE_DRAIN, 16'h1234, 6'd0);
		push_req(MODE_DRAIN, 16'h0000, 6'd63);
		push_req(MODE_DRAIN, 16'h0000, 6'd42);
		push_req(MODE_DRAIN, 16'h0000, 6'd21);
		wait_drained();

		// Random counts over a small set of routines and threads, with drains.
		for (int i = 0; i < 16; i++) hot_routines[i] = 16'($urandom_range(16'hFFFF));
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 64 : (ph == 3) ? 20 : 0;
			for (int i = 0; i < 20; i++) begin
				if ($urandom_range(7) == 0)
					push_req(MODE_DRAIN, 16'($urandom_range(16'hFFFF)),
					         6'($urandom_range(3)));
				else
					push_req(MODE_COUNT, hot_routines[$urandom_range(15)],
					         6'(($urandom_range(9) == 0) ? $urandom_range(63) :
					            $urandom_range(3)));
			end
			if (ph == 2) begin
				// Hold new requests until all results of the ones in flight are back.
				wait_quiet = 1'b1;
				wait_drained();
				wait_quiet = 1'b0;
			end
		end
		for (int t = 0; t < 64; t++) push_req(MODE_DRAIN, 16'h0000, 6'(t));
		wait_drained();

		// Fill the routine slots on thread 7 until counts are lost, mix in other threads, then drain it twice.
		idle_pct = 20;
		for (int i = 0; i < 60; i++)
			push_req(MODE_COUNT, 16'($urandom_range(16'hFFFF)), 6'd7);
		for (int i = 0; i < 20; i++)
			push_req(MODE_COUNT, hot_routines[$urandom_range(15)],
			         6'($urandom_range(63)));
		push_req(MODE_DRAIN, 16'h0000, 6'd7);
		push_req(MODE_DRAIN, 16'h0000, 6'd7);

		// Mixed tail against a full routine table.
		idle_pct = 0;
		for (int i = 0; i < 30; i++) begin
			if ($urandom_range(5) == 0)
				push_req(MODE_DRAIN, 16'($urandom_range(16'hFFFF)),
				         6'($urandom_range(63)));
			else if ($urandom_range(1) == 0)
				push_req(MODE_COUNT, hot_routines[$urandom_range(15)],
				         6'($urandom_range(63)));
			else
				push_req(MODE_COUNT, 16'($urandom_range(16'hFFFF)),
				         6'($urandom_range(63)));
		end
		for (int t = 0; t < 64; t++) push_req(MODE_DRAIN, 16'h0000, 6'(t));
		wait_drained();
		repeat (300) @(posedge clk);

		$display("Covered %0d count and %0d drain requests, %0d results checked.",
		         n_counts, n_drains, n_results);
		$display("Routine slots used: %0d, lost flag: %0d.", slots_taken, lost);
		if (errors == 0 && expected_res.size() == 0) begin
			$display("per_thread_routine_profile_table_tb OK");
		end else begin
			$display("per_thread_routine_profile_table_tb NOT OK");
		end
		$finish;
	end
endmodule

@@ files.f @@
+incdir+hdl
hdl/ptrp_pkg.sv
hdl/ptrp_ram.sv
hdl/per_thread_routine_profile_table.sv
tb/per_thread_routine_profile_table_tb.sv
